// ----- src/lbvs_pkg.sv -----
// ----------------------------------------------------------------------------
// lbvs_pkg
// Shared types, constants and helpers for the linear blend vertex skinner.
// ----------------------------------------------------------------------------
package lbvs_pkg;

  localparam int unsigned WORDS_PER_JOINT = 12;
  localparam int unsigned NUM_INFL        = 4;
  localparam int unsigned JOINT_W         = 6;
  localparam int unsigned WEIGHT_W        = 16;
  localparam int unsigned ACC_W           = 40;
  localparam int unsigned ROOT_STEPS      = 32;
  localparam int unsigned DIV_STEPS       = 16;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_SKIN = 1'b1;

  typedef struct packed {
    logic        func;
    logic [9:0]  matrix_addr;
    logic [31:0] matrix_value;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [15:0] norm_x;
    logic [15:0] norm_y;
    logic [15:0] norm_z;
    logic [23:0] joints_packed;
    logic [63:0] weights_packed;
    logic        last_vertex;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] out_pos_x;
    logic [31:0] out_pos_y;
    logic [31:0] out_pos_z;
    logic [15:0] out_norm_x;
    logic [15:0] out_norm_y;
    logic [15:0] out_norm_z;
    logic        last;
  } out_beat_t;

  typedef struct packed {
    logic        en;
    logic [3:0]  elem;
    logic [31:0] data;
  } bone_wr_t;

  typedef struct packed {
    logic start;
    logic take;
    logic last;
  } norm_ctl_t;

  typedef struct packed {
    logic      valid;
    out_beat_t beat;
  } norm_res_t;

  function automatic logic [31:0] sat32(input logic signed [49:0] x);
    logic [31:0] r;
    if (x > 50'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (x < -50'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// ----- src/lbvs_bone_mem.sv -----
// ----------------------------------------------------------------------------
// lbvs_bone_mem
// Bone table as twelve banks, one per matrix word, so a whole joint reads at once.
// ----------------------------------------------------------------------------
module lbvs_bone_mem import lbvs_pkg::*; #(
  parameter int unsigned MAX_JOINTS = 64,
  parameter int unsigned IDX_W      = 6
) (
  input  logic                                 clk_i,
  input  bone_wr_t                             wr_i,
  input  logic [IDX_W-1:0]                     wr_idx_i,
  input  logic [IDX_W-1:0]                     rd_idx_i,
  output logic [WORDS_PER_JOINT-1:0][31:0]     rd_words_o
);

  for (genvar e = 0; e < WORDS_PER_JOINT; e++) begin : g_bank
    logic [31:0] bank [MAX_JOINTS];
    logic [31:0] rd_q;

    always_ff @(posedge clk_i) begin
      if (wr_i.en && (wr_i.elem == 4'(e))) begin
        bank[wr_idx_i] <= wr_i.data;
      end
    end

    always_ff @(posedge clk_i) begin
      rd_q <= bank[rd_idx_i];
    end

    assign rd_words_o[e] = rd_q;
  end

endmodule

// ----- src/lbvs_row_lane.sv -----
// ----------------------------------------------------------------------------
// lbvs_row_lane
// One output row: rotate, offset, weight and accumulate over the influences.
// ----------------------------------------------------------------------------
module lbvs_row_lane import lbvs_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        clr_i,
  input  logic                        vld_i,
  input  logic [WEIGHT_W-1:0]         w_i,
  input  logic [2:0][31:0]            m_i,
  input  logic [31:0]                 off_i,
  input  logic [2:0][31:0]            p_i,
  input  logic [2:0][15:0]            n_i,
  output logic [ACC_W-1:0]            acc_p_o,
  output logic [ACC_W-1:0]            acc_n_o
);

  logic               v2_q, v3_q, v4_q;
  logic [WEIGHT_W-1:0] w2_q, w3_q;
  logic signed [63:0] pp_q [3];
  logic signed [47:0] np_q [3];
  logic [31:0]        off_q;
  logic signed [31:0] tp_q;
  logic signed [33:0] tn_q;
  logic signed [48:0] prp_q;
  logic signed [50:0] prn_q;
  logic signed [ACC_W-1:0] acc_p_q, acc_n_q;
  logic signed [49:0] sum_p;
  logic signed [33:0] sum_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v2_q <= vld_i;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // products
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      pp_q[c] <= $signed(m_i[c]) * $signed(p_i[c]);
      np_q[c] <= $signed(m_i[c]) * $signed(n_i[c]);
    end
    off_q <= off_i;
    w2_q  <= w_i;
  end

  always_comb begin
    sum_p = 50'($signed(pp_q[0][63:16])) + 50'($signed(pp_q[1][63:16]))
          + 50'($signed(pp_q[2][63:16])) + 50'($signed(off_q));
    sum_n = 34'($signed(np_q[0][47:16])) + 34'($signed(np_q[1][47:16]))
          + 34'($signed(np_q[2][47:16]));
  end

  always_ff @(posedge clk_i) begin
    tp_q <= $signed(sat32(sum_p));
    tn_q <= sum_n;
    w3_q <= w2_q;
  end

  // weighting
  always_ff @(posedge clk_i) begin
    prp_q <= tp_q * $signed({1'b0, w3_q});
    prn_q <= tn_q * $signed({1'b0, w3_q});
  end

  always_ff @(posedge clk_i) begin
    if (clr_i) begin
      acc_p_q <= '0;
      acc_n_q <= '0;
    end else if (v4_q) begin
      acc_p_q <= acc_p_q + ACC_W'($signed(prp_q[48:15]));
      acc_n_q <= acc_n_q + ACC_W'($signed(prn_q[50:15]));
    end
  end

  assign acc_p_o = acc_p_q;
  assign acc_n_o = acc_n_q;

endmodule

// ----- src/lbvs_norm.sv -----
// ----------------------------------------------------------------------------
// lbvs_norm
// Merge stage: saturate the lane sums, square root of the normal length and
// three restoring dividers for the unit normal.
// ----------------------------------------------------------------------------
module lbvs_norm import lbvs_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  norm_ctl_t                ctl_i,
  input  logic [2:0][ACC_W-1:0]    acc_p_i,
  input  logic [2:0][ACC_W-1:0]    acc_n_i,
  output norm_res_t                res_o
);

  localparam logic [2:0] N_IDLE = 3'd0;
  localparam logic [2:0] N_SQR  = 3'd1;
  localparam logic [2:0] N_SUM  = 3'd2;
  localparam logic [2:0] N_ROOT = 3'd3;
  localparam logic [2:0] N_PREP = 3'd4;
  localparam logic [2:0] N_DIV  = 3'd5;
  localparam logic [2:0] N_DONE = 3'd6;

  logic [2:0]  state_q, state_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] pos_q [3];
  logic [31:0] nrm_q [3];
  logic [31:0] mag   [3];
  logic [63:0] sq_q  [3];
  logic [63:0] rem_q, res_q, bit_q;
  logic        zero_q, last_q;
  logic [31:0] drem_q [3];
  logic [15:0] nsh_q  [3];
  logic [15:0] quo_q  [3];
  logic [15:0] nout   [3];
  logic [63:0] trial;
  logic [63:0] ssum;
  logic [31:0] len;

  assign len = res_q[31:0];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      mag[r] = nrm_q[r][31] ? 32'(-nrm_q[r]) : nrm_q[r];
    end
    trial = res_q + bit_q;
    ssum  = sq_q[0] + sq_q[1] + sq_q[2];
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      N_IDLE: if (ctl_i.start) state_d = N_SQR;
      N_SQR:  state_d = N_SUM;
      N_SUM: begin
        state_d = N_ROOT;
        cnt_d   = '0;
      end
      N_ROOT: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(ROOT_STEPS - 1)) state_d = N_PREP;
      end
      N_PREP: begin
        state_d = N_DIV;
        cnt_d   = '0;
      end
      N_DIV: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(DIV_STEPS - 1)) state_d = N_DONE;
      end
      N_DONE: if (ctl_i.take) state_d = N_IDLE;
      default: state_d = N_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      N_IDLE: begin
        for (int r = 0; r < 3; r++) begin
          pos_q[r] <= sat32(50'($signed(acc_p_i[r])));
          nrm_q[r] <= sat32(50'($signed(acc_n_i[r])));
        end
        last_q <= ctl_i.last;
      end
      N_SQR: begin
        for (int r = 0; r < 3; r++) begin
          sq_q[r] <= 64'(mag[r]) * 64'(mag[r]);
        end
      end
      N_SUM: begin
        rem_q  <= ssum;
        zero_q <= (ssum == 64'd0);
        res_q  <= '0;
        bit_q  <= 64'h4000_0000_0000_0000;
      end
      N_ROOT: begin
        if (rem_q >= trial) begin
          rem_q <= rem_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      N_PREP: begin
        for (int r = 0; r < 3; r++) begin
          logic [47:0] num;
          num       = {1'b0, mag[r], 15'b0} + 48'(len >> 1);
          drem_q[r] <= num[47:16];
          nsh_q[r]  <= num[15:0];
          quo_q[r]  <= '0;
        end
      end
      N_DIV: begin
        for (int r = 0; r < 3; r++) begin
          logic [32:0] r2;
          r2 = {drem_q[r], nsh_q[r][15]};
          if (r2 >= {1'b0, len}) begin
            drem_q[r] <= 32'(r2 - {1'b0, len});
            quo_q[r]  <= {quo_q[r][14:0], 1'b1};
          end else begin
            drem_q[r] <= r2[31:0];
            quo_q[r]  <= {quo_q[r][14:0], 1'b0};
          end
          nsh_q[r] <= {nsh_q[r][14:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      if (zero_q) begin
        nout[r] = nrm_q[r][15:0];
      end else if (nrm_q[r][31]) begin
        nout[r] = (quo_q[r] > 16'd32768) ? 16'h8000 : 16'(~quo_q[r] + 16'd1);
      end else begin
        nout[r] = (quo_q[r] > 16'd32767) ? 16'h7FFF : quo_q[r];
      end
    end
  end

  assign res_o.valid           = (state_q == N_DONE);
  assign res_o.beat.out_pos_x  = pos_q[0];
  assign res_o.beat.out_pos_y  = pos_q[1];
  assign res_o.beat.out_pos_z  = pos_q[2];
  assign res_o.beat.out_norm_x = nout[0];
  assign res_o.beat.out_norm_y = nout[1];
  assign res_o.beat.out_norm_z = nout[2];
  assign res_o.beat.last       = last_q;

endmodule

// ----- src/linear_blend_vertex_skinner.sv -----
// ----------------------------------------------------------------------------
// linear_blend_vertex_skinner
// Four-influence linear blend skinning of one vertex per beat, fixed point.
//
//   channel | direction | handshake             | payload
//   in      | sink      | in_valid_i / in_stall_o  | in_data_i  (in_beat_t)
//   out     | source    | out_valid_o / out_stall_i | out_data_o (out_beat_t)
//
// a load beat writes one bone word and the next beat is taken right after.
// a skin beat holds the input until its result moves to the output register:
// four influences issue one joint per cycle from the banked bone table into
// three row lanes, then the merge stage runs a 32-step square root and 16-step dividers.
// the bone table has no reset and no clearing pass; control resets async.
// one finished result waits in the output register while the next beat runs.
// ----------------------------------------------------------------------------
module linear_blend_vertex_skinner import lbvs_pkg::*; #(
  parameter int unsigned MAX_JOINTS = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  localparam int unsigned IDX_W = $clog2(MAX_JOINTS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_NORM = 2'd2;

  logic [1:0] state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  in_beat_t   item_q;
  logic       in_acc, skin_acc;

  logic [19:0] div_prod;
  logic [6:0]  wr_joint;
  logic [9:0]  wr_base;
  bone_wr_t    wr;

  logic [1:0]          infl;
  logic [JOINT_W-1:0]  joint;
  logic [WEIGHT_W-1:0] weight;
  logic                v0;
  logic                v1_q;
  logic [WEIGHT_W-1:0] w1_q;
  logic [WORDS_PER_JOINT-1:0][31:0] words;

  logic [2:0][31:0]       pvec;
  logic [2:0][15:0]       nvec;
  logic [2:0][ACC_W-1:0]  acc_p, acc_n;
  norm_ctl_t              nctl;
  norm_res_t              nres;

  logic      out_valid_q;
  out_beat_t out_q;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign skin_acc   = in_acc && (in_data_i.func == FUNC_SKIN);

  // address split into joint and word, addr / 12 by reciprocal
  assign div_prod = 20'(in_data_i.matrix_addr) * 20'd683;
  assign wr_joint = div_prod[19:13];
  assign wr_base  = 10'({wr_joint, 3'b000}) + 10'({wr_joint, 2'b00});
  assign wr.en    = in_acc && (in_data_i.func == FUNC_LOAD)
                 && (32'(in_data_i.matrix_addr) < 32'(MAX_JOINTS * WORDS_PER_JOINT));
  assign wr.elem  = 4'(in_data_i.matrix_addr - wr_base);
  assign wr.data  = in_data_i.matrix_value;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (skin_acc) begin
          state_d = S_RUN;
          cnt_d   = '0;
        end
      end
      S_RUN: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd8) state_d = S_NORM;
      end
      S_NORM: if (nctl.take) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      v1_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      v1_q    <= v0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skin_acc) item_q <= in_data_i;
    w1_q <= weight;
  end

  // influence issue, one joint per cycle
  assign infl   = cnt_q[1:0];
  assign joint  = item_q.joints_packed[JOINT_W*infl +: JOINT_W];
  assign weight = item_q.weights_packed[WEIGHT_W*infl +: WEIGHT_W];
  assign v0     = (state_q == S_RUN) && (cnt_q < 4'(NUM_INFL)) && (weight != '0)
               && (32'(joint) < 32'(MAX_JOINTS));

  lbvs_bone_mem #(
    .MAX_JOINTS(MAX_JOINTS),
    .IDX_W     (IDX_W)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .wr_idx_i  (IDX_W'(wr_joint)),
    .rd_idx_i  (IDX_W'(joint)),
    .rd_words_o(words)
  );

  assign pvec = {item_q.pos_z, item_q.pos_y, item_q.pos_x};
  assign nvec = {item_q.norm_z, item_q.norm_y, item_q.norm_x};

  for (genvar r = 0; r < 3; r++) begin : g_lane
    lbvs_row_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .clr_i  (skin_acc),
      .vld_i  (v1_q),
      .w_i    (w1_q),
      .m_i    ({words[3*r+2], words[3*r+1], words[3*r]}),
      .off_i  (words[9+r]),
      .p_i    (pvec),
      .n_i    (nvec),
      .acc_p_o(acc_p[r]),
      .acc_n_o(acc_n[r])
    );
  end

  assign nctl.start = (state_q == S_RUN) && (cnt_q == 4'd8);
  assign nctl.take  = nres.valid && (!out_valid_q || !out_stall_i);
  assign nctl.last  = item_q.last_vertex;

  lbvs_norm u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (nctl),
    .acc_p_i(acc_p),
    .acc_n_i(acc_n),
    .res_o  (nres)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (nctl.take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (nctl.take) out_q <= nres.beat;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- src/lbvs_checker.sv -----
// ----------------------------------------------------------------------------
// lbvs_checker
// Port-level checks on the skinner handshakes, bound to the top level.
// ----------------------------------------------------------------------------
module lbvs_checker import lbvs_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_beat_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_beat_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.func == FUNC_LOAD) |=> !in_stall_o)
    else $error("load beat blocked the input");

  a_skin_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.func == FUNC_SKIN) |=> in_stall_o)
    else $error("skin beat did not occupy the engine");

endmodule

bind linear_blend_vertex_skinner lbvs_checker u_lbvs_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);
